@@ hdl/top_k_dedup_beam_list_defines.svh @@
// Assertion macros for the top-k candidate list
`ifndef TOP_K_DEDUP_BEAM_LIST_DEFINES_SVH
`define TOP_K_DEDUP_BEAM_LIST_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset
`define TKDBL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TKDBL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tkdbl_pkg.sv @@
// Shared types, codes and helpers of the top-k candidate list
`timescale 1ns / 1ps
package tkdbl_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int KEY_W       = 64;
	localparam int SCORE_W     = 32;

	typedef logic [1:0]                 cmd_t;
	typedef logic [2:0]                 status_t;
	typedef logic [IDX_W-1:0]           idx_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [KEY_W-1:0]           key_t;
	typedef logic signed [SCORE_W-1:0]  score_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_CLEAR  = 2'd1;
	localparam cmd_t CMD_READ   = 2'd2;

	localparam status_t ST_APPEND  = 3'd0;
	localparam status_t ST_REPLACE = 3'd1;
	localparam status_t ST_DUP     = 3'd2;
	localparam status_t ST_REJECT  = 3'd3;
	localparam status_t ST_CLEAR   = 3'd4;
	localparam status_t ST_READ    = 3'd5;

	localparam cnt_t LIMIT_RESET = cnt_t'(MAX_ENTRIES);

	// Clamp the programmed limit into 1..MAX_ENTRIES
	function automatic cnt_t eff_limit(input cnt_t cap);
		cnt_t r;
		if (cap == '0) begin
			r = cnt_t'(1);
		end else if (cap > cnt_t'(MAX_ENTRIES)) begin
			r = cnt_t'(MAX_ENTRIES);
		end else begin
			r = cap;
		end
		return r;
	endfunction

endpackage

@@ hdl/tkdbl_req_if.sv @@
// Request channel: command word with candidate and read slot
`timescale 1ns / 1ps
interface tkdbl_req_if;
	logic                  valid;
	logic                  ready;
	tkdbl_pkg::cmd_t       command;
	tkdbl_pkg::key_t       cand_key;
	tkdbl_pkg::score_t     cand_score;
	tkdbl_pkg::idx_t       read_slot;

	modport source (output valid, command, cand_key, cand_score, read_slot, input ready);
	modport sink (input valid, command, cand_key, cand_score, read_slot, output ready);
endinterface

@@ hdl/tkdbl_rsp_if.sv @@
// Response channel: one result word per request
`timescale 1ns / 1ps
interface tkdbl_rsp_if;
	logic                  valid;
	logic                  ready;
	tkdbl_pkg::status_t    status;
	tkdbl_pkg::idx_t       slot_index;
	tkdbl_pkg::key_t       out_key;
	tkdbl_pkg::score_t     out_score;
	tkdbl_pkg::cnt_t       entry_total;

	modport source (output valid, status, slot_index, out_key, out_score, entry_total,
		input ready);
	modport sink (input valid, status, slot_index, out_key, out_score, entry_total,
		output ready);
endinterface

@@ hdl/tkdbl_cfg_if.sv @@
// Configuration write channel for the capacity limit
`timescale 1ns / 1ps
interface tkdbl_cfg_if;
	logic              valid;
	logic              ready;
	tkdbl_pkg::cnt_t   capacity_limit;

	modport source (output valid, capacity_limit, input ready);
	modport sink (input valid, capacity_limit, output ready);
endinterface

@@ hdl/top_k_dedup_beam_list.sv @@
// Top-k candidate list with duplicate suppression and min replacement
//
// Channels: req (command, cand_key, cand_score, read_slot) in, rsp (status,
// slot_index, out_key, out_score, entry_total) out, cfg writes capacity_limit.
// Every req word gives exactly one rsp word. One request is in flight at a time.
// Keys and scores sit in a 16-entry single-port-read RAM with registered read;
// an insert scans the valid entries one per cycle for a key match and the
// minimum score, then decides append / replace / reject and writes back.
// Path from req accept to rsp valid, ending in the output register:
//   insert: S_SCAN over the valid entries, S_DECIDE, S_OUT; a key match goes
//           from S_SCAN straight to S_OUT, an empty list skips S_SCAN
//   read:   S_RDATA, S_OUT; clear and unused command: S_OUT
// req is ready again in the cycle rsp valid rises, so a new word is taken
// only once the previous one has reached the output register.
// The next req is taken once the result has moved into the output register,
// so a result waiting on rsp.ready does not block the following request.
// If rsp stalls with a result already held, the finished result waits in
// place and req stays low until the output register frees up.
// Reset: list empty, capacity_limit 16, rsp.valid low. RAM contents are not
// cleared; entries at or above the count are never returned.
`timescale 1ns / 1ps
`include "top_k_dedup_beam_list_defines.svh"
module top_k_dedup_beam_list (
	input logic          clk,
	input logic          arst_n,
	tkdbl_req_if.sink    req,
	tkdbl_rsp_if.source  rsp,
	tkdbl_cfg_if.sink    cfg
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_RDATA  = 3'd3;
	localparam logic [2:0] S_OUT    = 3'd4;

	logic [2:0]           state_q;
	tkdbl_pkg::cnt_t      count_q;
	tkdbl_pkg::cnt_t      cap_q;

	// latched request
	tkdbl_pkg::key_t      cand_key_q;
	tkdbl_pkg::score_t    cand_score_q;
	tkdbl_pkg::idx_t      read_slot_q;

	// scan bookkeeping
	tkdbl_pkg::idx_t      scan_idx_q;
	tkdbl_pkg::idx_t      data_idx_q;
	tkdbl_pkg::score_t    min_score_q;
	tkdbl_pkg::key_t      min_key_q;
	tkdbl_pkg::idx_t      min_slot_q;

	// finished result, waiting for the output register
	tkdbl_pkg::status_t   res_status_q;
	tkdbl_pkg::idx_t      res_slot_q;
	tkdbl_pkg::key_t      res_key_q;
	tkdbl_pkg::score_t    res_score_q;

	// output register
	logic                 out_valid_q;
	tkdbl_pkg::status_t   out_status_q;
	tkdbl_pkg::idx_t      out_slot_q;
	tkdbl_pkg::key_t      out_key_q;
	tkdbl_pkg::score_t    out_score_q;
	tkdbl_pkg::cnt_t      out_total_q;

	// entry RAM
	tkdbl_pkg::key_t      key_mem [tkdbl_pkg::MAX_ENTRIES];
	tkdbl_pkg::score_t    score_mem [tkdbl_pkg::MAX_ENTRIES];
	tkdbl_pkg::key_t      rd_key_s1;
	tkdbl_pkg::score_t    rd_score_s1;
	tkdbl_pkg::idx_t      rd_addr;
	logic                 wr_en;
	tkdbl_pkg::idx_t      wr_addr;

	logic                 req_fire;
	logic                 out_free;
	logic                 key_hit;
	logic                 take_min;
	logic                 last_entry;
	logic                 at_limit;
	logic                 beats_min;
	tkdbl_pkg::cnt_t      limit;

	assign req.ready  = (state_q == S_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign cfg.ready  = 1'b1;
	assign out_free   = !out_valid_q || rsp.ready;

	assign limit      = tkdbl_pkg::eff_limit(cap_q);
	assign key_hit    = (rd_key_s1 == cand_key_q);
	assign take_min   = (data_idx_q == '0) || (rd_score_s1 < min_score_q);
	assign last_entry = ({1'b0, data_idx_q} == (count_q - tkdbl_pkg::cnt_t'(1)));
	assign at_limit   = (count_q >= limit);
	assign beats_min  = (cand_score_q > min_score_q);

	assign rd_addr = (state_q == S_IDLE)
		? ((req.command == tkdbl_pkg::CMD_READ) ? req.read_slot : '0)
		: scan_idx_q;

	assign wr_en   = (state_q == S_DECIDE) && (!at_limit || beats_min);
	assign wr_addr = at_limit ? min_slot_q : count_q[tkdbl_pkg::IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]   <= cand_key_q;
			score_mem[wr_addr] <= cand_score_q;
		end
		rd_key_s1   <= key_mem[rd_addr];
		rd_score_s1 <= score_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= tkdbl_pkg::LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cap_q <= cfg.capacity_limit;
		end
	end

	// sequencer and payload bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						cand_key_q   <= req.cand_key;
						cand_score_q <= req.cand_score;
						read_slot_q  <= req.read_slot;
						scan_idx_q   <= tkdbl_pkg::idx_t'(1);
						data_idx_q   <= '0;
						unique case (req.command)
							tkdbl_pkg::CMD_INSERT: begin
								state_q <= (count_q == '0) ? S_DECIDE : S_SCAN;
							end
							tkdbl_pkg::CMD_CLEAR: begin
								count_q      <= '0;
								res_status_q <= tkdbl_pkg::ST_CLEAR;
								res_slot_q   <= '0;
								res_key_q    <= '0;
								res_score_q  <= '0;
								state_q      <= S_OUT;
							end
							tkdbl_pkg::CMD_READ: begin
								state_q <= S_RDATA;
							end
							default: begin
								res_status_q <= tkdbl_pkg::ST_REJECT;
								res_slot_q   <= '0;
								res_key_q    <= '0;
								res_score_q  <= '0;
								state_q      <= S_OUT;
							end
						endcase
					end
				end
				S_SCAN: begin
					// RAM data for data_idx_q is valid this cycle
					if (key_hit) begin
						res_status_q <= tkdbl_pkg::ST_DUP;
						res_slot_q   <= data_idx_q;
						res_key_q    <= rd_key_s1;
						res_score_q  <= rd_score_s1;
						state_q      <= S_OUT;
					end else begin
						if (take_min) begin
							min_score_q <= rd_score_s1;
							min_key_q   <= rd_key_s1;
							min_slot_q  <= data_idx_q;
						end
						scan_idx_q <= scan_idx_q + tkdbl_pkg::idx_t'(1);
						data_idx_q <= data_idx_q + tkdbl_pkg::idx_t'(1);
						if (last_entry) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (!at_limit) begin
						res_status_q <= tkdbl_pkg::ST_APPEND;
						res_slot_q   <= count_q[tkdbl_pkg::IDX_W-1:0];
						res_key_q    <= cand_key_q;
						res_score_q  <= cand_score_q;
						count_q      <= count_q + tkdbl_pkg::cnt_t'(1);
					end else if (beats_min) begin
						res_status_q <= tkdbl_pkg::ST_REPLACE;
						res_slot_q   <= min_slot_q;
						res_key_q    <= cand_key_q;
						res_score_q  <= cand_score_q;
					end else begin
						res_status_q <= tkdbl_pkg::ST_REJECT;
						res_slot_q   <= min_slot_q;
						res_key_q    <= min_key_q;
						res_score_q  <= min_score_q;
					end
					state_q <= S_OUT;
				end
				S_RDATA: begin
					res_status_q <= tkdbl_pkg::ST_READ;
					res_slot_q   <= read_slot_q;
					if ({1'b0, read_slot_q} < count_q) begin
						res_key_q   <= rd_key_s1;
						res_score_q <= rd_score_s1;
					end else begin
						res_key_q   <= '0;
						res_score_q <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_key_q    <= res_key_q;
			out_score_q  <= res_score_q;
			out_total_q  <= count_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.slot_index  = out_slot_q;
	assign rsp.out_key     = out_key_q;
	assign rsp.out_score   = out_score_q;
	assign rsp.entry_total = out_total_q;

	`TKDBL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= tkdbl_pkg::cnt_t'(tkdbl_pkg::MAX_ENTRIES),
		"entry count above capacity")
	`TKDBL_ASSERT_NOW(a_scan_in_range, state_q == S_SCAN, ({1'b0, data_idx_q} < count_q),
		"scan past the valid entries")
	`TKDBL_ASSERT_NEXT(a_one_in_flight, req_fire, !req.ready,
		"second request taken while one is in flight")
	`TKDBL_ASSERT_NOW(a_append_total, out_valid_q && out_status_q == tkdbl_pkg::ST_APPEND,
		out_total_q == ({1'b0, out_slot_q} + tkdbl_pkg::cnt_t'(1)),
		"append slot does not match entry total")

endmodule

@@ bench/tb_top_k_dedup_beam_list.sv @@
// Testbench for the top-k candidate list: queued command words checked against a shadow list
`timescale 1ns / 1ps
module tb_top_k_dedup_beam_list;

	localparam tkdbl_pkg::cmd_t CMD_UNUSED = 2'd3;

	localparam int IDLE_PCT       = 19;
	localparam int HOLD_AT        = 60;
	localparam int HOLD_CYCLES    = 300;
	localparam int CALM_FROM      = 400;
	localparam int CALM_TO        = 520;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 40;

	localparam tkdbl_pkg::key_t   KEY_A     = 64'h8000_0000_0000_0001;
	localparam tkdbl_pkg::key_t   KEY_B     = 64'h0123_4567_89AB_CDEF;
	localparam tkdbl_pkg::key_t   KEY_C     = 64'hFEDC_BA98_7654_3210;
	localparam tkdbl_pkg::key_t   KEY_ONES  = '1;
	localparam tkdbl_pkg::score_t SCORE_MAX = 32'h7FFF_FFFF;
	localparam tkdbl_pkg::score_t SCORE_MIN = 32'h8000_0000;

	typedef struct {
		tkdbl_pkg::cmd_t   command;
		tkdbl_pkg::key_t   cand_key;
		tkdbl_pkg::score_t cand_score;
		tkdbl_pkg::idx_t   read_slot;
	} cand_word_t;

	typedef struct {
		tkdbl_pkg::status_t status;
		tkdbl_pkg::idx_t    slot_index;
		tkdbl_pkg::key_t    out_key;
		tkdbl_pkg::score_t  out_score;
		tkdbl_pkg::cnt_t    entry_total;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	tkdbl_req_if req_ch ();
	tkdbl_rsp_if rsp_ch ();
	tkdbl_cfg_if cfg_ch ();

	top_k_dedup_beam_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// shadow copy of the list
	tkdbl_pkg::key_t   shadow_key   [tkdbl_pkg::MAX_ENTRIES];
	tkdbl_pkg::score_t shadow_score [tkdbl_pkg::MAX_ENTRIES];
	int                shadow_count = 0;
	tkdbl_pkg::cnt_t   shadow_limit = tkdbl_pkg::LIMIT_RESET;

	cand_word_t      cmd_backlog [$];
	outcome_t        due_outcomes [$];
	tkdbl_pkg::key_t key_pool [8];

	int   words_taken  = 0;
	int   results_seen = 0;
	int   mismatches   = 0;
	int   quiet_cycles = 0;
	int   hold_left    = 0;
	bit   hold_done    = 1'b0;
	logic calm;

	assign calm = (words_taken >= CALM_FROM) && (words_taken < CALM_TO);

	task automatic report_mismatch(input string what);
		$display("tb mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Apply one command word to the shadow list and return the word it answers with
	function automatic outcome_t list_outcome(input cand_word_t w);
		outcome_t          r;
		int                lim;
		int                i;
		int                low_slot;
		tkdbl_pkg::score_t low_score;
		bit                matched;
		r = '{status: tkdbl_pkg::ST_REJECT, slot_index: '0, out_key: '0, out_score: '0,
			entry_total: '0};
		low_slot = 0;
		low_score = '0;
		matched = 1'b0;
		if (shadow_limit == 0) begin
			lim = 1;
		end else if (shadow_limit > tkdbl_pkg::MAX_ENTRIES) begin
			lim = tkdbl_pkg::MAX_ENTRIES;
		end else begin
			lim = shadow_limit;
		end
		case (w.command)
			tkdbl_pkg::CMD_CLEAR: begin
				shadow_count = 0;
				r.status = tkdbl_pkg::ST_CLEAR;
			end
			tkdbl_pkg::CMD_READ: begin
				r.status = tkdbl_pkg::ST_READ;
				r.slot_index = w.read_slot;
				if (w.read_slot < shadow_count) begin
					r.out_key = shadow_key[w.read_slot];
					r.out_score = shadow_score[w.read_slot];
				end
			end
			tkdbl_pkg::CMD_INSERT: begin
				for (i = 0; i < shadow_count && !matched; i++) begin
					if (shadow_key[i] == w.cand_key) begin
						matched = 1'b1;
						r.status = tkdbl_pkg::ST_DUP;
						r.slot_index = tkdbl_pkg::idx_t'(i);
						r.out_key = shadow_key[i];
						r.out_score = shadow_score[i];
					end else if (i == 0 || shadow_score[i] < low_score) begin
						// strict compare keeps the lowest slot on ties
						low_score = shadow_score[i];
						low_slot = i;
					end
				end
				if (!matched) begin
					if (shadow_count < lim) begin
						shadow_key[shadow_count] = w.cand_key;
						shadow_score[shadow_count] = w.cand_score;
						r.status = tkdbl_pkg::ST_APPEND;
						r.slot_index = tkdbl_pkg::idx_t'(shadow_count);
						shadow_count++;
					end else if (w.cand_score > low_score) begin
						shadow_key[low_slot] = w.cand_key;
						shadow_score[low_slot] = w.cand_score;
						r.status = tkdbl_pkg::ST_REPLACE;
						r.slot_index = tkdbl_pkg::idx_t'(low_slot);
					end else begin
						r.status = tkdbl_pkg::ST_REJECT;
						r.slot_index = tkdbl_pkg::idx_t'(low_slot);
					end
					if (r.status != tkdbl_pkg::ST_REJECT) begin
						r.out_key = w.cand_key;
						r.out_score = w.cand_score;
					end else begin
						r.out_key = shadow_key[low_slot];
						r.out_score = shadow_score[low_slot];
					end
				end
			end
			default: begin
			end
		endcase
		r.entry_total = tkdbl_pkg::cnt_t'(shadow_count);
		return r;
	endfunction

	function automatic void queue_word(input tkdbl_pkg::cmd_t c, input tkdbl_pkg::key_t k,
		input tkdbl_pkg::score_t s, input tkdbl_pkg::idx_t slot);
		cmd_backlog.insert(cmd_backlog.size(),
			'{command: c, cand_key: k, cand_score: s, read_slot: slot});
	endfunction

	// Mostly inserts over a small key pool (duplicates) and narrow scores (ties)
	function automatic void random_phase(input int n);
		int                pick;
		tkdbl_pkg::key_t   k;
		tkdbl_pkg::score_t s;
		tkdbl_pkg::idx_t   slot;
		repeat (n) begin
			pick = $urandom_range(99);
			k = ($urandom_range(99) < 45) ? key_pool[$urandom_range(7)] : {$urandom, $urandom};
			s = ($urandom_range(1) == 1) ? tkdbl_pkg::score_t'(int'($urandom_range(16)) - 8)
				: tkdbl_pkg::score_t'($urandom);
			slot = tkdbl_pkg::idx_t'($urandom);
			if (pick < 2) begin
				queue_word(tkdbl_pkg::CMD_CLEAR, k, s, slot);
			end else if (pick < 4) begin
				queue_word(CMD_UNUSED, k, s, slot);
			end else if (pick < 22) begin
				queue_word(tkdbl_pkg::CMD_READ, k, s, slot);
			end else begin
				queue_word(tkdbl_pkg::CMD_INSERT, k, s, slot);
			end
		end
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || req_ch.valid || due_outcomes.size() != 0);
	endtask

	task automatic write_limit(input tkdbl_pkg::cnt_t value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.capacity_limit <= value;
		do @(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Driver: predicts on each taken word, then offers the next one
	always @(posedge clk) begin
		cand_word_t w;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				w.command = req_ch.command;
				w.cand_key = req_ch.cand_key;
				w.cand_score = req_ch.cand_score;
				w.read_slot = req_ch.read_slot;
				due_outcomes.insert(due_outcomes.size(), list_outcome(w));
				words_taken <= words_taken + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					w = cmd_backlog.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.command <= w.command;
					req_ch.cand_key <= w.cand_key;
					req_ch.cand_score <= w.cand_score;
					req_ch.read_slot <= w.read_slot;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, one long hold-off so the block backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				rsp_ch.ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Monitor: each result word against the oldest expectation
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen <= results_seen + 1;
			if (due_outcomes.size() == 0) begin
				report_mismatch($sformatf("result word with nothing expected, status %0d",
					rsp_ch.status));
			end else begin
				want = due_outcomes.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						rsp_ch.status, want.status));
				if (rsp_ch.slot_index !== want.slot_index)
					report_mismatch($sformatf("slot_index got %0d want %0d",
						rsp_ch.slot_index, want.slot_index));
				if (rsp_ch.out_key !== want.out_key)
					report_mismatch($sformatf("out_key got %h want %h",
						rsp_ch.out_key, want.out_key));
				if (rsp_ch.out_score !== want.out_score)
					report_mismatch($sformatf("out_score got %h want %h",
						rsp_ch.out_score, want.out_score));
				if (rsp_ch.entry_total !== want.entry_total)
					report_mismatch($sformatf("entry_total got %0d want %0d",
						rsp_ch.entry_total, want.entry_total));
			end
		end
	end

	always @(posedge clk) begin
		if (cfg_ch.valid && cfg_ch.ready && arst_n) begin
			shadow_limit = cfg_ch.capacity_limit;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.command = tkdbl_pkg::CMD_INSERT;
		req_ch.cand_key = '0;
		req_ch.cand_score = '0;
		req_ch.read_slot = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.capacity_limit = tkdbl_pkg::LIMIT_RESET;
		arst_n = 1'b0;
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: limit 2, empty list, duplicates, ties, extremes
		write_limit(tkdbl_pkg::cnt_t'(2));
		queue_word(tkdbl_pkg::CMD_READ, '0, '0, tkdbl_pkg::idx_t'(0));
		queue_word(tkdbl_pkg::CMD_INSERT, '0, '0, '0);
		queue_word(tkdbl_pkg::CMD_INSERT, KEY_ONES, SCORE_MAX, '0);
		queue_word(tkdbl_pkg::CMD_INSERT, '0, tkdbl_pkg::score_t'(5), '0);
		queue_word(tkdbl_pkg::CMD_INSERT, KEY_A, '0, '0);
		queue_word(tkdbl_pkg::CMD_INSERT, KEY_A, tkdbl_pkg::score_t'(1), '0);
		queue_word(tkdbl_pkg::CMD_INSERT, KEY_B, SCORE_MIN, '1);
		queue_word(tkdbl_pkg::CMD_READ, '0, '0, tkdbl_pkg::idx_t'(1));
		queue_word(tkdbl_pkg::CMD_READ, '0, '0, '1);
		queue_word(CMD_UNUSED, KEY_ONES, tkdbl_pkg::score_t'(-1), '1);
		queue_word(tkdbl_pkg::CMD_CLEAR, KEY_C, SCORE_MAX, '1);
		queue_word(tkdbl_pkg::CMD_INSERT, KEY_A, tkdbl_pkg::score_t'(-1), '0);
		queue_word(tkdbl_pkg::CMD_INSERT, KEY_B, tkdbl_pkg::score_t'(-1), '0);
		queue_word(tkdbl_pkg::CMD_INSERT, KEY_C, '0, '0);
		queue_word(tkdbl_pkg::CMD_READ, '0, '0, tkdbl_pkg::idx_t'(0));
		queue_word(tkdbl_pkg::CMD_READ, '0, '0, tkdbl_pkg::idx_t'(1));
		queue_word(tkdbl_pkg::CMD_INSERT, KEY_ONES, SCORE_MIN, '0);
		queue_word(tkdbl_pkg::CMD_CLEAR, '0, '0, '0);
		wait_idle();

		write_limit(tkdbl_pkg::cnt_t'(16));
		random_phase(150);
		wait_idle();
		write_limit(tkdbl_pkg::cnt_t'(31));
		random_phase(80);
		wait_idle();
		write_limit(tkdbl_pkg::cnt_t'(1));
		random_phase(60);
		wait_idle();
		write_limit(tkdbl_pkg::cnt_t'(0));
		random_phase(60);
		wait_idle();
		write_limit(tkdbl_pkg::cnt_t'(5));
		random_phase(80);
		wait_idle();
		write_limit(tkdbl_pkg::cnt_t'(20));
		random_phase(80);
		wait_idle();

		// fill all 16 slots, then drop the limit below the count
		write_limit(tkdbl_pkg::cnt_t'(16));
		queue_word(tkdbl_pkg::CMD_CLEAR, '0, '0, '0);
		repeat (16) queue_word(tkdbl_pkg::CMD_INSERT, {$urandom, $urandom},
			tkdbl_pkg::score_t'($urandom), '0);
		wait_idle();
		write_limit(tkdbl_pkg::cnt_t'(3));
		random_phase(100);
		wait_idle();
		write_limit(tkdbl_pkg::cnt_t'(16));
		random_phase(70);
		wait_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_outcomes.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", due_outcomes.size()));
		end
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
